// ----- rtl/tcw_pkg.sv -----
// Shared constants, widths and control types for the text console character writer.
// Used by the controller, the datapath and the top level; depends on nothing else.
package tcw_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 4;
    localparam int CELLS    = COLS * ROWS;
    localparam int KEEP     = CELLS - COLS;

    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CNT_W    = $clog2(CELLS + 1);
    localparam int POS_W    = $clog2(CELLS + COLS + TAB_STOP + 1);
    localparam int COL_W    = $clog2(COLS);
    localparam int TPH_W    = $clog2(TAB_STOP + 1);
    localparam int COLS_MOD_TAB = COLS % TAB_STOP;

    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int CELL_W   = 16;
    localparam int PADDR_W  = 2;
    localparam int PDATA_W  = 32;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [CELL_W-1:0] CELL_RESET   = 16'h0F20;
    localparam logic [CELL_W-1:0] CELL_NEWLINE = 16'h0000;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic scroll_step;
        logic load_item;
        logic read_issue;
        logic exec;
        logic tab_step;
    } tcw_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scroll_last;
        logic is_read;
        logic is_tab;
        logic past_end;
        logic tab_last;
    } tcw_status_t;

endpackage

// ----- rtl/tcw_ctrl.sv -----
// Controller state machine of the text console character writer.
// Depends on tcw_pkg for the command and status types.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        out_free,
    input  tcw_status_t status,
    output tcw_cmd_t    cmd,
    output logic        idle,
    output logic        out_load
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b00000001,
        S_IDLE   = 8'b00000010,
        S_PRE    = 8'b00000100,
        S_SCROLL = 8'b00001000,
        S_EXEC   = 8'b00010000,
        S_TAB    = 8'b00100000,
        S_POST   = 8'b01000000,
        S_DONE   = 8'b10000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   post_reg;
    logic   post_next;

    always_comb
    begin
        state_next = state_reg;
        post_next  = post_reg;
        cmd        = '0;
        idle       = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                idle = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_PRE;
                end
            end
            S_PRE:
            begin
                if (status.is_read)
                begin
                    cmd.read_issue = 1'b1;
                    state_next     = S_DONE;
                end
                else if (status.past_end)
                begin
                    post_next  = 1'b0;
                    state_next = S_SCROLL;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
                if (status.scroll_last)
                begin
                    state_next = post_reg ? S_DONE : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.is_tab)
                begin
                    cmd.tab_step = 1'b1;
                    state_next   = status.tab_last ? S_POST : S_TAB;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_POST;
                end
            end
            S_TAB:
            begin
                cmd.tab_step = 1'b1;
                if (status.tab_last)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (status.past_end)
                begin
                    post_next  = 1'b1;
                    state_next = S_SCROLL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    idle     = 1'b1;
                    if (req_valid)
                    begin
                        cmd.load_item = 1'b1;
                        state_next    = S_PRE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            post_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            post_reg  <= post_next;
        end
    end

endmodule

// ----- rtl/tcw_datapath.sv -----
// Datapath of the text console character writer: screen memory, cursor tracking and sweeps.
// Depends on tcw_pkg; driven by commands from tcw_ctrl.
module tcw_datapath
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_cmd_t          cmd,
    output tcw_status_t       status,
    input  logic [ATTR_W-1:0] attr,
    input  logic              func,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [IDX_W-1:0]  cell_index,
    output logic [IDX_W-1:0]  res_cursor,
    output logic [CELL_W-1:0] res_cell
);

    logic [CELL_W-1:0] cell_mem [CELLS];

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  cursor_reg, cursor_next;
    logic [POS_W-1:0]  line_reg, line_next;
    logic [POS_W-1:0]  row_base_reg, row_base_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [TPH_W-1:0]  tph_reg, tph_next;
    logic [TPH_W-1:0]  rb_tph_reg, rb_tph_next;
    logic              func_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CELL_W-1:0] rdata_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;

    logic              past_end;
    logic              idx_ok;
    logic              bs_move;
    logic [POS_W-1:0]  cur_dec;
    logic [POS_W-1:0]  bs_target;

    logic [POS_W-1:0]  adv_cursor;
    logic [COL_W-1:0]  adv_col;
    logic [POS_W-1:0]  adv_row_base;
    logic [TPH_W-1:0]  adv_tph;
    logic [TPH_W-1:0]  adv_rb_tph;

    function automatic logic [TPH_W-1:0] tph_inc(input logic [TPH_W-1:0] v);
        return (v == TPH_W'(TAB_STOP - 1)) ? '0 : v + TPH_W'(1);
    endfunction

    function automatic logic [TPH_W-1:0] tph_dec(input logic [TPH_W-1:0] v);
        return (v == '0) ? TPH_W'(TAB_STOP - 1) : v - TPH_W'(1);
    endfunction

    function automatic logic [TPH_W-1:0] tph_add_cols(input logic [TPH_W-1:0] v);
        logic [TPH_W:0] s;
        s = {1'b0, v} + (TPH_W + 1)'(COLS_MOD_TAB);
        return (s >= (TPH_W + 1)'(TAB_STOP)) ? TPH_W'(s - (TPH_W + 1)'(TAB_STOP)) : TPH_W'(s);
    endfunction

    function automatic logic [TPH_W-1:0] tph_sub_cols(input logic [TPH_W-1:0] v);
        return (v >= TPH_W'(COLS_MOD_TAB)) ? v - TPH_W'(COLS_MOD_TAB)
                                            : v + TPH_W'(TAB_STOP - COLS_MOD_TAB);
    endfunction

    assign past_end  = cursor_reg >= POS_W'(CELLS);
    assign idx_ok    = 32'(idx_reg) < CELLS;
    assign bs_move   = line_reg < cursor_reg;
    assign cur_dec   = cursor_reg - POS_W'(1);
    assign bs_target = bs_move ? cur_dec : cursor_reg;

    assign status.clear_last  = cnt_reg == CNT_W'(CELLS - 1);
    assign status.scroll_last = cnt_reg == CNT_W'(CELLS);
    assign status.is_read     = func_reg == FUNC_READ;
    assign status.is_tab      = ch_reg == CH_TAB;
    assign status.past_end    = past_end;
    assign status.tab_last    = tph_reg == TPH_W'(TAB_STOP - 1);

    assign res_cursor = IDX_W'(cursor_reg);
    assign res_cell   = (status.is_read && idx_ok) ? rdata_reg : '0;

    always_comb
    begin
        adv_cursor   = cursor_reg + POS_W'(1);
        adv_tph      = tph_inc(tph_reg);
        adv_row_base = row_base_reg;
        adv_rb_tph   = rb_tph_reg;
        if (col_reg == COL_W'(COLS - 1))
        begin
            adv_col      = '0;
            adv_row_base = row_base_reg + POS_W'(COLS);
            adv_rb_tph   = tph_add_cols(rb_tph_reg);
        end
        else
        begin
            adv_col = col_reg + COL_W'(1);
        end
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        cursor_next   = cursor_reg;
        line_next     = line_reg;
        row_base_next = row_base_reg;
        col_next      = col_reg;
        tph_next      = tph_reg;
        rb_tph_next   = rb_tph_reg;
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;
        re            = 1'b0;
        raddr         = '0;

        if (cmd.clear_step)
        begin
            we       = 1'b1;
            waddr    = ADDR_W'(cnt_reg);
            wdata    = CELL_RESET;
            cnt_next = status.clear_last ? '0 : cnt_reg + CNT_W'(1);
        end

        if (cmd.scroll_step)
        begin
            if (cnt_reg < CNT_W'(KEEP))
            begin
                re    = 1'b1;
                raddr = ADDR_W'(cnt_reg + CNT_W'(COLS));
            end
            if (cnt_reg != '0)
            begin
                we    = 1'b1;
                waddr = ADDR_W'(cnt_reg - CNT_W'(1));
                wdata = (cnt_reg <= CNT_W'(KEEP)) ? rdata_reg : {attr, CH_SPACE};
            end
            if (status.scroll_last)
            begin
                cnt_next      = '0;
                cursor_next   = cursor_reg - POS_W'(COLS);
                row_base_next = row_base_reg - POS_W'(COLS);
                line_next     = (line_reg >= POS_W'(COLS)) ? line_reg - POS_W'(COLS) : '0;
                tph_next      = tph_sub_cols(tph_reg);
                rb_tph_next   = tph_sub_cols(rb_tph_reg);
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        if (cmd.read_issue)
        begin
            re    = idx_ok;
            raddr = ADDR_W'(idx_reg);
        end

        if (cmd.tab_step)
        begin
            cursor_next   = adv_cursor;
            col_next      = adv_col;
            row_base_next = adv_row_base;
            tph_next      = adv_tph;
            rb_tph_next   = adv_rb_tph;
        end

        if (cmd.exec)
        begin
            unique case (ch_reg)
                CH_NUL, CH_TAB:
                begin
                end
                CH_LF:
                begin
                    we            = !past_end;
                    waddr         = ADDR_W'(cursor_reg);
                    wdata         = CELL_NEWLINE;
                    row_base_next = row_base_reg + POS_W'(COLS);
                    cursor_next   = row_base_reg + POS_W'(COLS);
                    line_next     = row_base_reg + POS_W'(COLS);
                    col_next      = '0;
                    tph_next      = tph_add_cols(rb_tph_reg);
                    rb_tph_next   = tph_add_cols(rb_tph_reg);
                end
                CH_CR:
                begin
                    cursor_next = row_base_reg;
                    line_next   = row_base_reg;
                    col_next    = '0;
                    tph_next    = rb_tph_reg;
                end
                CH_BS:
                begin
                    if (bs_move)
                    begin
                        cursor_next = cur_dec;
                        tph_next    = tph_dec(tph_reg);
                        if (col_reg == '0)
                        begin
                            col_next      = COL_W'(COLS - 1);
                            row_base_next = row_base_reg - POS_W'(COLS);
                            rb_tph_next   = tph_sub_cols(rb_tph_reg);
                        end
                        else
                        begin
                            col_next = col_reg - COL_W'(1);
                        end
                    end
                    we    = bs_target < POS_W'(CELLS);
                    waddr = ADDR_W'(bs_target);
                    wdata = {attr, CH_NUL};
                end
                default:
                begin
                    we            = !past_end;
                    waddr         = ADDR_W'(cursor_reg);
                    wdata         = {attr, ch_reg};
                    cursor_next   = adv_cursor;
                    col_next      = adv_col;
                    row_base_next = adv_row_base;
                    tph_next      = adv_tph;
                    rb_tph_next   = adv_rb_tph;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cell_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= cell_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg <= func;
            ch_reg   <= char_code;
            idx_reg  <= cell_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            cursor_reg   <= '0;
            line_reg     <= '0;
            row_base_reg <= '0;
            col_reg      <= '0;
            tph_reg      <= '0;
            rb_tph_reg   <= '0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            cursor_reg   <= cursor_next;
            line_reg     <= line_next;
            row_base_reg <= row_base_next;
            col_reg      <= col_next;
            tph_reg      <= tph_next;
            rb_tph_reg   <= rb_tph_next;
        end
    end

endmodule

// ----- rtl/text_console_char_writer.sv -----
// Top level of the text console character writer: APB register, result register and glue.
// A put runs PRE, EXEC and POST before its result, a read only PRE; each scroll adds a copy sweep.
// The next transfer is taken in the same cycle as the result loads.
// A tab adds single-cell steps up to the next tab stop. The memory copy during a scroll sets the worst case.
// After reset the screen memory is cleared cell by cell while input transfers stall.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
module text_console_char_writer
    import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               func,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic [IDX_W-1:0]   cell_index,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [IDX_W-1:0]   cursor_pos,
    output logic [CELL_W-1:0]  cell_value
);

    tcw_cmd_t          cmd;
    tcw_status_t       status;
    logic              idle;
    logic              out_load;
    logic              out_free;
    logic [ATTR_W-1:0] attr_reg;
    logic [IDX_W-1:0]  res_cursor;
    logic [CELL_W-1:0] res_cell;
    logic              rsp_valid_reg;
    logic [IDX_W-1:0]  cursor_pos_reg;
    logic [CELL_W-1:0] cell_value_reg;

    // With a single register, every byte offset on the bus addresses it.
    assign pready = 1'b1;
    assign prdata = PDATA_W'(attr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == '0 || paddr != '0))
        begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !idle;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .out_free  (out_free),
        .status    (status),
        .cmd       (cmd),
        .idle      (idle),
        .out_load  (out_load)
    );

    tcw_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .attr       (attr_reg),
        .func       (func),
        .char_code  (char_code),
        .cell_index (cell_index),
        .res_cursor (res_cursor),
        .res_cell   (res_cell)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cursor_pos_reg <= res_cursor;
            cell_value_reg <= res_cell;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign cursor_pos = cursor_pos_reg;
    assign cell_value = cell_value_reg;

endmodule
